@@ hdl/drdma_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and sizes of the two-requester block-copy engine
package drdma_pkg;

  localparam int DATA_W           = 32;
  localparam int REG_COUNT        = 8;
  localparam int REG_ACCESS_BYTES = 4;
  localparam int BUFFER_WORDS     = 256;
  localparam int BUF_AW           = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
  localparam int POS_W            = $clog2(BUFFER_WORDS + 1);
  localparam int CAP_BYTES        = 4 * BUFFER_WORDS;
  localparam int BYTES_W          = $clog2(CAP_BYTES + 1);

  typedef enum logic [1:0] {
    OP_REG_WRITE = 2'd0,
    OP_REG_READ  = 2'd1,
    OP_TICK      = 2'd2,
    OP_MEM_DATA  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_NONE         = 3'd0,
    KIND_ACCESS_OK    = 3'd1,
    KIND_BUSY         = 3'd2,
    KIND_ACCESS_ERROR = 3'd3,
    KIND_READ_REQ     = 3'd4,
    KIND_WRITE_WORD   = 3'd5,
    KIND_FAULT        = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_READ  = 3'd1,
    PH_WRITE = 3'd2,
    PH_DONE  = 3'd3,
    PH_FAULT = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    SLOT_SRC   = 2'd0,
    SLOT_TGT   = 2'd1,
    SLOT_SIZE  = 2'd2,
    SLOT_START = 2'd3
  } slot_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [7:0]          reg_byte_addr;
    logic [3:0]          access_bytes;
    logic [DATA_W-1:0]   bus_data;
    logic                bus_fault;
  } item_t;

  typedef struct packed {
    kind_t               result_kind;
    logic [DATA_W-1:0]   mem_addr;
    logic [BYTES_W-1:0]  mem_bytes;
    logic [DATA_W-1:0]   mem_word;
    logic                last_word;
    logic                irq_first;
    logic                irq_second;
    logic                serving;
  } result_t;

  // owner's view of the register file, seen by the copy sequencer
  typedef struct packed {
    logic                owner;
    logic                start_any;
    logic                start_own;
    logic [DATA_W-1:0]   src_addr;
    logic [DATA_W-1:0]   tgt_addr;
    logic [BYTES_W-1:0]  size_bytes;
  } chan_view_t;

  typedef struct packed {
    kind_t               kind;
    logic                owner_next;
  } access_status_t;

  typedef struct packed {
    kind_t               kind;
    logic [DATA_W-1:0]   mem_addr;
    logic [BYTES_W-1:0]  mem_bytes;
    logic [DATA_W-1:0]   mem_word;
    logic                last_word;
    logic [1:0]          irq_next;
    logic                release_claim;
  } copy_status_t;

endpackage

@@ hdl/drdma_ram.sv @@
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module drdma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/drdma_regs.sv @@
`timescale 1ns / 1ps
// per-requester register file with engine claim and busy answer
module drdma_regs (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  drdma_pkg::item_t         item,
  input  logic                     release_claim,
  output drdma_pkg::chan_view_t    view,
  output drdma_pkg::access_status_t status
);

  logic [drdma_pkg::DATA_W-1:0]  src_addr   [2];
  logic [drdma_pkg::DATA_W-1:0]  tgt_addr   [2];
  logic [drdma_pkg::BYTES_W-1:0] size_bytes [2];
  logic [1:0]                    start_set;
  logic                          claimed;
  logic                          owner;

  logic [5:0]                    widx;
  logic                          who;
  logic                          bad;
  logic                          busy;
  logic                          is_access;
  logic                          take_claim;
  logic                          wr_en;
  logic                          wr_who;
  drdma_pkg::slot_t              wr_slot;
  logic [drdma_pkg::BYTES_W-1:0] size_clamped;

  always_comb begin
    widx       = item.reg_byte_addr[7:2];
    who        = |widx[5:2];
    bad        = (widx > 6'(drdma_pkg::REG_COUNT - 1)) ||
                 (item.access_bytes != 4'(drdma_pkg::REG_ACCESS_BYTES));
    is_access  = (item.opcode == drdma_pkg::OP_REG_WRITE) ||
                 (item.opcode == drdma_pkg::OP_REG_READ);
    busy       = claimed && (who != owner);
    take_claim = fire && is_access && !busy;
    wr_en      = take_claim && !bad && (item.opcode == drdma_pkg::OP_REG_WRITE);
    wr_who     = widx[2];
    wr_slot    = drdma_pkg::slot_t'(widx[1:0]);
    // byte size kept already clamped to the buffer
    size_clamped = (item.bus_data > drdma_pkg::DATA_W'(drdma_pkg::CAP_BYTES)) ?
                   drdma_pkg::BYTES_W'(drdma_pkg::CAP_BYTES) :
                   item.bus_data[drdma_pkg::BYTES_W-1:0];
  end

  always_comb begin
    if (!is_access) begin
      status.kind = drdma_pkg::KIND_NONE;
    end else if (busy) begin
      status.kind = drdma_pkg::KIND_BUSY;
    end else if (bad) begin
      status.kind = drdma_pkg::KIND_ACCESS_ERROR;
    end else begin
      status.kind = drdma_pkg::KIND_ACCESS_OK;
    end
    status.owner_next = take_claim ? who : owner;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      claimed <= 1'b0;
      owner   <= 1'b0;
    end else if (take_claim) begin
      claimed <= 1'b1;
      owner   <= who;
    end else if (release_claim) begin
      claimed <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_addr[0]   <= '0;
      src_addr[1]   <= '0;
      tgt_addr[0]   <= '0;
      tgt_addr[1]   <= '0;
      size_bytes[0] <= '0;
      size_bytes[1] <= '0;
      start_set     <= '0;
    end else if (wr_en) begin
      unique case (wr_slot)
        drdma_pkg::SLOT_SRC:   src_addr[wr_who]   <= item.bus_data;
        drdma_pkg::SLOT_TGT:   tgt_addr[wr_who]   <= item.bus_data;
        drdma_pkg::SLOT_SIZE:  size_bytes[wr_who] <= size_clamped;
        drdma_pkg::SLOT_START: start_set[wr_who]  <= |item.bus_data;
      endcase
    end
  end

  always_comb begin
    view.owner      = owner;
    view.start_any  = |start_set;
    view.start_own  = start_set[owner];
    view.src_addr   = src_addr[owner];
    view.tgt_addr   = tgt_addr[owner];
    view.size_bytes = size_bytes[owner];
  end

  // release only comes from a tick, never together with a claim
  a_release_on_tick: assert property (@(posedge clk) disable iff (rst)
    release_claim |-> (fire && (item.opcode == drdma_pkg::OP_TICK)))
    else $error("claim released outside a tick");

  // while the claim lasts the owner cannot move
  a_owner_held: assert property (@(posedge clk) disable iff (rst)
    (claimed && $past(claimed) && !$past(rst)) |-> (owner == $past(owner)))
    else $error("owner changed during claim");

endmodule

@@ hdl/drdma_copy.sv @@
`timescale 1ns / 1ps
// copy sequencer: read request, buffer fill, write-out and completion irq
module drdma_copy (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  drdma_pkg::item_t       item,
  input  drdma_pkg::chan_view_t  view,
  output drdma_pkg::copy_status_t status
);

  drdma_pkg::phase_t             phase;
  drdma_pkg::phase_t             phase_next;
  logic [drdma_pkg::POS_W-1:0]   word_pos;
  logic [drdma_pkg::POS_W-1:0]   word_pos_next;
  logic [drdma_pkg::POS_W-1:0]   word_total;
  logic [drdma_pkg::POS_W-1:0]   word_total_next;
  logic [1:0]                    irq_levels;
  logic [1:0]                    irq_next;

  logic                          is_tick;
  logic                          is_data;
  logic [drdma_pkg::BYTES_W-1:0] total_wide;
  logic [drdma_pkg::POS_W-1:0]   total_new;
  logic [drdma_pkg::POS_W-1:0]   pos_inc;
  logic                          pos_end;
  logic [drdma_pkg::DATA_W-1:0]  tgt_word_addr;

  logic                          buf_we;
  logic [drdma_pkg::BUF_AW-1:0]  buf_waddr;
  logic [drdma_pkg::BUF_AW-1:0]  buf_raddr;
  logic [drdma_pkg::DATA_W-1:0]  ram_q;
  logic [drdma_pkg::DATA_W-1:0]  buf_word;
  logic                          fwd_valid;
  logic [drdma_pkg::DATA_W-1:0]  fwd_data;

  always_comb begin
    is_tick    = fire && (item.opcode == drdma_pkg::OP_TICK);
    is_data    = fire && (item.opcode == drdma_pkg::OP_MEM_DATA);
    // words = bytes / 4 rounded up
    total_wide = drdma_pkg::BYTES_W'(view.size_bytes[drdma_pkg::BYTES_W-1:2]) +
                 drdma_pkg::BYTES_W'(|view.size_bytes[1:0]);
    total_new  = total_wide[drdma_pkg::POS_W-1:0];
    pos_inc    = word_pos + drdma_pkg::POS_W'(1);
    pos_end    = pos_inc >= word_total;
    tgt_word_addr = view.tgt_addr + drdma_pkg::DATA_W'({word_pos, 2'b00});
  end

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      drdma_pkg::PH_IDLE: begin
        if (is_tick && view.start_any) begin
          phase_next = (total_new == '0) ? drdma_pkg::PH_DONE : drdma_pkg::PH_READ;
        end
      end
      drdma_pkg::PH_READ: begin
        if (is_data) begin
          if (item.bus_fault) begin
            phase_next = drdma_pkg::PH_FAULT;
          end else if (pos_end) begin
            phase_next = drdma_pkg::PH_WRITE;
          end
        end
      end
      drdma_pkg::PH_WRITE: begin
        if (is_tick) begin
          if (item.bus_fault) begin
            phase_next = drdma_pkg::PH_FAULT;
          end else if (pos_end) begin
            phase_next = drdma_pkg::PH_DONE;
          end
        end
      end
      drdma_pkg::PH_DONE: begin
        if (is_tick && !view.start_own) begin
          phase_next = drdma_pkg::PH_IDLE;
        end
      end
      drdma_pkg::PH_FAULT: phase_next = drdma_pkg::PH_FAULT;
      default:             phase_next = drdma_pkg::PH_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    word_pos_next        = word_pos;
    word_total_next      = word_total;
    irq_next             = irq_levels;
    buf_we               = 1'b0;
    status.kind          = drdma_pkg::KIND_NONE;
    status.mem_addr      = '0;
    status.mem_bytes     = '0;
    status.mem_word      = '0;
    status.last_word     = 1'b0;
    status.release_claim = 1'b0;
    unique case (phase)
      drdma_pkg::PH_IDLE: begin
        if (is_tick && view.start_any) begin
          word_total_next  = total_new;
          word_pos_next    = '0;
          status.kind      = drdma_pkg::KIND_READ_REQ;
          status.mem_addr  = view.src_addr;
          status.mem_bytes = view.size_bytes;
        end
      end
      drdma_pkg::PH_READ: begin
        if (is_data) begin
          if (item.bus_fault) begin
            status.kind = drdma_pkg::KIND_FAULT;
          end else begin
            buf_we        = 1'b1;
            word_pos_next = pos_end ? '0 : pos_inc;
          end
        end
      end
      drdma_pkg::PH_WRITE: begin
        if (is_tick) begin
          status.mem_addr = tgt_word_addr;
          if (item.bus_fault) begin
            status.kind = drdma_pkg::KIND_FAULT;
          end else begin
            status.kind      = drdma_pkg::KIND_WRITE_WORD;
            status.mem_word  = buf_word;
            status.last_word = pos_end;
            word_pos_next    = pos_end ? '0 : pos_inc;
          end
        end
      end
      drdma_pkg::PH_DONE: begin
        if (is_tick) begin
          if (!view.start_own) begin
            irq_next[view.owner] = 1'b0;
            status.release_claim = 1'b1;
          end else begin
            irq_next[view.owner] = 1'b1;
          end
        end
      end
      drdma_pkg::PH_FAULT: begin
        if (is_tick) begin
          status.kind = drdma_pkg::KIND_FAULT;
        end
      end
      default: begin
        word_pos_next = '0;
      end
    endcase
    status.irq_next = irq_next;
  end

  // read port always looks at the entry the next item will want
  assign buf_waddr = word_pos[drdma_pkg::BUF_AW-1:0];
  assign buf_raddr = word_pos_next[drdma_pkg::BUF_AW-1:0];
  assign buf_word  = fwd_valid ? fwd_data : ram_q;

  drdma_ram #(
    .WIDTH (drdma_pkg::DATA_W),
    .DEPTH (drdma_pkg::BUFFER_WORDS)
  ) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (item.bus_data),
    .raddr (buf_raddr),
    .rdata (ram_q)
  );

  // same-entry write and read in one cycle: hand the new word over
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= buf_we && (buf_waddr == buf_raddr);
    end
    fwd_data <= item.bus_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= drdma_pkg::PH_IDLE;
      word_pos   <= '0;
      word_total <= '0;
      irq_levels <= '0;
    end else begin
      phase      <= phase_next;
      word_pos   <= word_pos_next;
      word_total <= word_total_next;
      irq_levels <= irq_next;
    end
  end

  a_irq_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(irq_levels))
    else $error("both interrupt levels high");

  a_irq_idle_low: assert property (@(posedge clk) disable iff (rst)
    (phase == drdma_pkg::PH_IDLE) |-> (irq_levels == 2'b00))
    else $error("interrupt left high while idle");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    ((phase == drdma_pkg::PH_READ) || (phase == drdma_pkg::PH_WRITE)) |->
      (word_pos < word_total))
    else $error("word position beyond burst length");

endmodule

@@ hdl/dual_requester_dma_controller.sv @@
`timescale 1ns / 1ps
// top level of the two-requester block-copy engine
//
//  channel  | valid        | stall        | word
//  ---------+--------------+--------------+------------------------------------
//  item     | item_valid   | item_stall   | item   : register access, tick, data
//  result   | result_valid | result_stall | result : one answer per item
//
// each item is handled in the cycle it is accepted; one item per cycle sustained while item_stall stays low
// the result is registered in the output register, or in the skid register while the output is stalled
// buffer word for a write tick is prefetched from the copy ram ahead of the tick,
//   with a bypass when the same entry was just written
// a skid register takes one result while the output is stalled; item_stall
//   rises only when the skid register is full
// reset (rst, synchronous) clears owner, claim, registers, phase and irq levels;
//   the copy buffer itself is not cleared
module dual_requester_dma_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  drdma_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_stall,
  output drdma_pkg::result_t result
);

  logic                      fire;
  logic                      take;
  drdma_pkg::chan_view_t     view;
  drdma_pkg::access_status_t acc_status;
  drdma_pkg::copy_status_t   copy_status;
  drdma_pkg::result_t        result_new;
  drdma_pkg::result_t        skid;
  logic                      skid_valid;
  logic                      is_access;

  assign item_stall = skid_valid;
  assign fire       = item_valid && !item_stall;
  assign take       = result_valid && !result_stall;

  // register file: claim, busy answer, source/target/size/start per requester
  drdma_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .item          (item),
    .release_claim (copy_status.release_claim),
    .view          (view),
    .status        (acc_status)
  );

  // copy sequencer around the buffer ram
  drdma_copy u_copy (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .view   (view),
    .status (copy_status)
  );

  // register accesses answer from the register file, the rest from the sequencer
  always_comb begin
    is_access = (item.opcode == drdma_pkg::OP_REG_WRITE) ||
                (item.opcode == drdma_pkg::OP_REG_READ);
    result_new.result_kind = is_access ? acc_status.kind : copy_status.kind;
    result_new.mem_addr    = copy_status.mem_addr;
    result_new.mem_bytes   = copy_status.mem_bytes;
    result_new.mem_word    = copy_status.mem_word;
    result_new.last_word   = copy_status.last_word;
    result_new.irq_first   = copy_status.irq_next[0];
    result_new.irq_second  = copy_status.irq_next[1];
    result_new.serving     = acc_status.owner_next;
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (fire) begin
      if (!result_valid || take) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (!result_valid || take) begin
        result <= result_new;
      end else begin
        skid <= result_new;
      end
    end else if (take && skid_valid) begin
      result <= skid;
    end
  end

  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid word held with empty output register");

  a_stall_keeps_result: assert property (@(posedge clk) disable iff (rst)
    ($past(result_valid) && $past(result_stall) && !$past(rst)) |->
      (result_valid && (result == $past(result))))
    else $error("stalled result changed");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for the two-requester block-copy engine, directed and random traffic
module tb;
  import drdma_pkg::*;

  localparam logic [3:0] ACC_LEN = 4'(REG_ACCESS_BYTES);

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  dual_requester_dma_controller dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // mirror of the engine state, updated once per accepted word
  logic [DATA_W-1:0] mirror_regs [REG_COUNT] = '{default: '0};
  logic [DATA_W-1:0] mirror_buf [BUFFER_WORDS];
  phase_t            mirror_phase   = PH_IDLE;
  logic              mirror_claimed = 1'b0;
  logic              mirror_owner   = 1'b0;
  logic [POS_W-1:0]  mirror_pos     = '0;
  logic [POS_W-1:0]  mirror_total   = '0;
  logic [1:0]        mirror_irq     = '0;

  result_t pending_answers [$];
  int      mismatches = 0;
  int      words_sent = 0;
  // chance in a hundred of a gap on the item side and a stall on the result side
  int      idle_pct   = 23;
  int      stall_pct  = 23;

  initial begin
    forever #5 clk = ~clk;
  end

  // generous ceiling, far above the slowest correct run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [DATA_W-1:0] chan_reg(logic who, slot_t slot);
    return mirror_regs[{who, slot}];
  endfunction

  // works out the answer to one accepted word and advances the mirror
  function automatic result_t predict_answer(item_t w);
    result_t     r;
    logic [5:0]  widx;
    logic        who;
    logic [31:0] size;
    logic        last;
    r = '0;
    r.result_kind = KIND_NONE;
    case (w.opcode)
      OP_REG_WRITE, OP_REG_READ: begin
        // low two address bits are dropped, so unaligned offsets hit the same word
        widx = w.reg_byte_addr[7:2];
        who  = (widx > 3);
        if (mirror_claimed && who != mirror_owner) begin
          r.result_kind = KIND_BUSY;
        end else begin
          // even a bad access claims the engine
          mirror_claimed = 1'b1;
          mirror_owner   = who;
          if (widx > 7 || w.access_bytes != ACC_LEN) begin
            r.result_kind = KIND_ACCESS_ERROR;
          end else begin
            if (w.opcode == OP_REG_WRITE) mirror_regs[widx[2:0]] = w.bus_data;
            r.result_kind = KIND_ACCESS_OK;
          end
        end
      end
      OP_MEM_DATA: begin
        // data outside the read phase is dropped, fault flag included
        if (mirror_phase == PH_READ) begin
          if (w.bus_fault) begin
            mirror_phase  = PH_FAULT;
            r.result_kind = KIND_FAULT;
          end else begin
            mirror_buf[mirror_pos] = w.bus_data;
            mirror_pos++;
            if (mirror_pos >= mirror_total) begin
              mirror_pos   = '0;
              mirror_phase = PH_WRITE;
            end
          end
        end
      end
      default: begin
        case (mirror_phase)
          PH_IDLE: begin
            if (chan_reg(1'b0, SLOT_START) != 0 || chan_reg(1'b1, SLOT_START) != 0) begin
              // byte count clamped to the buffer, word count rounded up
              size = chan_reg(mirror_owner, SLOT_SIZE);
              if (size > CAP_BYTES) size = CAP_BYTES;
              mirror_total  = POS_W'((size + 3) / 4);
              mirror_pos    = '0;
              r.result_kind = KIND_READ_REQ;
              r.mem_addr    = chan_reg(mirror_owner, SLOT_SRC);
              r.mem_bytes   = size[BYTES_W-1:0];
              mirror_phase  = (mirror_total == 0) ? PH_DONE : PH_READ;
            end
          end
          PH_WRITE: begin
            // target register is live: read again for every word
            r.mem_addr = chan_reg(mirror_owner, SLOT_TGT) + (32'(mirror_pos) << 2);
            if (w.bus_fault) begin
              mirror_phase  = PH_FAULT;
              r.result_kind = KIND_FAULT;
            end else begin
              last          = (mirror_pos + 1 >= mirror_total);
              r.result_kind = KIND_WRITE_WORD;
              r.mem_word    = mirror_buf[mirror_pos];
              r.last_word   = last;
              mirror_pos++;
              if (last) begin
                mirror_pos   = '0;
                mirror_phase = PH_DONE;
              end
            end
          end
          PH_DONE: begin
            // interrupt held until the owner clears start, which drops the claim
            if (chan_reg(mirror_owner, SLOT_START) == 0) begin
              mirror_irq[mirror_owner] = 1'b0;
              mirror_claimed           = 1'b0;
              mirror_phase             = PH_IDLE;
            end else begin
              mirror_irq[mirror_owner] = 1'b1;
            end
          end
          PH_FAULT: r.result_kind = KIND_FAULT;
          default: ;
        endcase
      end
    endcase
    r.irq_first  = mirror_irq[0];
    r.irq_second = mirror_irq[1];
    r.serving    = mirror_owner;
    return r;
  endfunction

  function automatic item_t make_item(opcode_t op, logic [7:0] addr, logic [3:0] len,
                                      logic [31:0] data, logic fault);
    item_t w;
    w.opcode        = op;
    w.reg_byte_addr = addr;
    w.access_bytes  = len;
    w.bus_data      = data;
    w.bus_fault     = fault;
    return w;
  endfunction

  // offers one word, holds it through stalls, predicts its answer on acceptance
  task automatic send_word(item_t w);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    if (!(w.opcode == OP_MEM_DATA && mirror_phase != PH_READ)) words_sent++;
    pending_answers.push_back(predict_answer(w));
  endtask

  task automatic reg_access(opcode_t op, logic who, slot_t slot, logic [31:0] data);
    send_word(make_item(op, {3'b000, who, slot, 2'($urandom_range(0, 3))}, ACC_LEN, data,
                        1'($urandom_range(0, 1))));
  endtask

  task automatic tick(logic fault);
    send_word(make_item(OP_TICK, 8'($urandom), 4'($urandom), $urandom, fault));
  endtask

  task automatic mem_data(logic [31:0] data, logic fault);
    send_word(make_item(OP_MEM_DATA, 8'($urandom), 4'($urandom), data, fault));
  endtask

  // stop sending until every answer is back
  task automatic drain_wait();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // walks the engine back to idle and unclaimed, or stops at a sticky fault
  task automatic settle();
    while (mirror_phase != PH_FAULT && (mirror_phase != PH_IDLE || mirror_claimed)) begin
      case (mirror_phase)
        PH_READ:  mem_data($urandom, 1'b0);
        PH_WRITE: tick(1'b0);
        PH_DONE: begin
          if (chan_reg(mirror_owner, SLOT_START) != 0)
            reg_access(OP_REG_WRITE, mirror_owner, SLOT_START, '0);
          else
            tick(1'b0);
        end
        default: begin
          // claimed while idle: only a finished copy drops the claim, so run a short one
          if (chan_reg(mirror_owner, SLOT_SIZE) > 64)
            reg_access(OP_REG_WRITE, mirror_owner, SLOT_SIZE, $urandom_range(0, 64));
          else if (chan_reg(mirror_owner, SLOT_START) == 0)
            reg_access(OP_REG_WRITE, mirror_owner, SLOT_START, 32'd1);
          else
            tick(1'b0);
        end
      endcase
    end
  endtask

  // one well-formed copy with random content and a little stray traffic
  task automatic run_copy(logic who, logic [31:0] src, logic [31:0] tgt, logic [31:0] size,
                          bit retarget);
    settle();
    reg_access(OP_REG_WRITE, who, SLOT_SRC, src);
    reg_access(OP_REG_WRITE, who, SLOT_TGT, tgt);
    reg_access(OP_REG_WRITE, who, SLOT_SIZE, size);
    // the other requester is turned away while the claim lasts
    if ($urandom_range(0, 3) == 0)
      reg_access(opcode_t'($urandom_range(0, 1)), !who, slot_t'($urandom_range(0, 3)), $urandom);
    reg_access(OP_REG_WRITE, who, SLOT_START, $urandom | 32'h1);
    tick(1'b0);
    while (mirror_phase == PH_READ) begin
      if ($urandom_range(0, 9) == 0) tick(1'($urandom_range(0, 1)));
      mem_data($urandom, 1'b0);
    end
    while (mirror_phase == PH_WRITE) begin
      if (retarget && $urandom_range(0, 3) == 0)
        reg_access(OP_REG_WRITE, mirror_owner, SLOT_TGT, $urandom);
      tick(1'b0);
    end
    repeat ($urandom_range(1, 3)) tick(1'b0);
    if ($urandom_range(0, 1)) begin
      reg_access(OP_REG_WRITE, who, SLOT_START, '0);
      tick(1'b0);
    end
  endtask

  task automatic test_register_access();
    send_word(make_item(OP_REG_READ, 8'h00, ACC_LEN, '1, 1'b1));
    reg_access(OP_REG_WRITE, 1'b0, SLOT_SRC, '0);
    reg_access(OP_REG_WRITE, 1'b0, SLOT_TGT, '1);
    send_word(make_item(OP_REG_READ, 8'hFF, ACC_LEN, '0, 1'b0));
    send_word(make_item(OP_REG_WRITE, 8'h10, ACC_LEN, '1, 1'b0));
    send_word(make_item(OP_REG_WRITE, 8'h00, 4'h0, '1, 1'b0));
    send_word(make_item(OP_REG_READ, 8'h04, 4'hF, '0, 1'b1));
    // unaligned write lands on the size word
    send_word(make_item(OP_REG_WRITE, 8'h0B, ACC_LEN, 32'd8, 1'b0));
    send_word(make_item(OP_MEM_DATA, 8'h00, 4'h0, 32'hDEAD_BEEF, 1'b1));
    send_word(make_item(OP_TICK, 8'h00, 4'h0, '0, 1'b1));
    settle();
    // word index out of range still claims, here for requester two
    send_word(make_item(OP_REG_WRITE, 8'hFF, ACC_LEN, '1, 1'b0));
    send_word(make_item(OP_REG_READ, 8'h20, ACC_LEN, '0, 1'b0));
    settle();
  endtask

  task automatic test_copy_edges();
    run_copy(1'b0, '0, 32'hFFFF_FFF8, '0, 1'b0);
    run_copy(1'b1, '1, '0, 32'd5, 1'b0);
    run_copy(1'b0, 32'h0000_1000, 32'hFFFF_FFF8, 32'd40, 1'b1);
    run_copy(1'b1, $urandom, $urandom, 32'd1, 1'b0);
    drain_wait();
  endtask

  task automatic test_size_clamp();
    run_copy(1'b1, $urandom, $urandom, '1, 1'b0);
    settle();
  endtask

  task automatic test_random_traffic();
    int    base;
    item_t w;
    base = words_sent;
    while (words_sent - base < 150) begin
      // a stretch with no gaps or stalls at all
      if (words_sent - base >= 30 && words_sent - base < 140) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 23;
        stall_pct = 23;
      end
      if ($urandom_range(0, 9) < 7) begin
        run_copy(1'($urandom_range(0, 1)), $urandom, $urandom,
                 ($urandom_range(0, 39) == 0) ? $urandom_range(65, 400) : $urandom_range(0, 48),
                 1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 8)) begin
          w = make_item(opcode_t'($urandom_range(0, 3)),
                        ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31)),
                        ($urandom_range(0, 3) == 0) ? 4'($urandom) : ACC_LEN,
                        $urandom, 1'($urandom_range(0, 1)));
          if (w.opcode == OP_REG_WRITE && w.reg_byte_addr[3:2] == SLOT_SIZE &&
              $urandom_range(0, 19) != 0)
            w.bus_data = $urandom_range(0, 64);
          // a fault would lock the engine for the rest of the run
          if ((w.opcode == OP_MEM_DATA && mirror_phase == PH_READ) ||
              (w.opcode == OP_TICK && mirror_phase == PH_WRITE))
            w.bus_fault = 1'b0;
          send_word(w);
        end
      end
    end
    idle_pct  = 23;
    stall_pct = 23;
  endtask

  // the fault is sticky until reset, so only one kind can be seen per run
  task automatic test_sticky_fault();
    logic on_read;
    on_read = 1'($urandom_range(0, 1));
    settle();
    reg_access(OP_REG_WRITE, 1'b0, SLOT_SRC, $urandom);
    reg_access(OP_REG_WRITE, 1'b0, SLOT_TGT, $urandom);
    reg_access(OP_REG_WRITE, 1'b0, SLOT_SIZE, 32'd16);
    reg_access(OP_REG_WRITE, 1'b0, SLOT_START, 32'd1);
    tick(1'b0);
    if (on_read) begin
      mem_data($urandom, 1'b0);
      mem_data($urandom, 1'b1);
    end else begin
      while (mirror_phase == PH_READ) mem_data($urandom, 1'b0);
      tick(1'b0);
      tick(1'b1);
    end
    repeat (3) tick(1'($urandom_range(0, 1)));
    reg_access(OP_REG_READ, 1'b0, SLOT_SIZE, '0);
    mem_data($urandom, 1'b1);
    reg_access(OP_REG_WRITE, 1'b0, SLOT_START, '0);
    tick(1'b0);
  endtask

  task automatic compare_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // result side: random stalls, every accepted word checked against the oldest answer
  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: result expected none got %p", $time, result);
          mismatches++;
        end else begin
          want = pending_answers.pop_front();
          compare_field("result_kind", want.result_kind, result.result_kind);
          compare_field("mem_addr", want.mem_addr, result.mem_addr);
          compare_field("mem_bytes", want.mem_bytes, result.mem_bytes);
          compare_field("mem_word", want.mem_word, result.mem_word);
          compare_field("last_word", want.last_word, result.last_word);
          compare_field("irq_first", want.irq_first, result.irq_first);
          compare_field("irq_second", want.irq_second, result.irq_second);
          compare_field("serving", want.serving, result.serving);
        end
      end
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_register_access();
    test_copy_edges();
    test_size_clamp();
    test_random_traffic();
    test_sticky_fault();
    drain_wait();
    // one result per word: the extra wait catches anything extra
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
